@@ design/three_voice_wave_sound_registers_top_assert.svh @@
// Assertion macros used by the checker of the sound register block.
// All of them sample on i_clk and are off while i_rst_n is low.
`ifndef THREE_VOICE_WAVE_SOUND_REGISTERS_TOP_ASSERT_SVH
`define THREE_VOICE_WAVE_SOUND_REGISTERS_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TVWSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TVWSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tvwsr_pkg.sv @@
package tvwsr_pkg;

    localparam int REG_COUNT  = 32;
    localparam int ADDR_W     = $clog2(REG_COUNT);
    localparam int NIB_W      = 4;
    localparam int VOICES_DEF = 3;
    localparam int VOICE_W    = 2;
    localparam int CMD_W      = 2;
    localparam int WAVE_W     = 3;
    localparam int LWAVE_W    = 4;
    localparam int VOL_W      = 8;
    localparam int DATA_W     = 8;
    localparam int RATE_W     = 22;
    localparam int FREQ_W     = 20;
    localparam int STEP_W     = 3;

    // rate = (3072000 / 2048) * f / 512
    localparam int RATE_MUL   = 3072000 / 2048;
    localparam int RATE_MUL_W = $clog2(RATE_MUL + 1);
    localparam int PROD_W     = FREQ_W + RATE_MUL_W;
    localparam int RATE_SHIFT = $clog2(512);

    localparam logic [LWAVE_W-1:0] LAST_WAVE_NONE = 4'hf;

    // register offsets of voice 0; voice v adds 5*v
    localparam logic [ADDR_W-1:0] REG_WAVE  = 5'h05;
    localparam logic [ADDR_W-1:0] REG_FREQ0 = 5'h10;
    localparam logic [ADDR_W-1:0] REG_FREQ1 = 5'h11;
    localparam logic [ADDR_W-1:0] REG_FREQ2 = 5'h12;
    localparam logic [ADDR_W-1:0] REG_FREQ3 = 5'h13;
    localparam logic [ADDR_W-1:0] REG_FREQ4 = 5'h14;
    localparam logic [ADDR_W-1:0] REG_VOL   = 5'h15;
    localparam logic [ADDR_W-1:0] VOICE_STRIDE = 5'd5;

    // fetch order of one voice
    localparam logic [STEP_W-1:0] STEP_WAVE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_F4    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_F3    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_F2    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_F1    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_F0    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_VOL   = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;

    typedef enum logic [1:0] {
        MODE_REG_WR = 2'd0,
        MODE_ENABLE = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLAY   = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_STOP   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_STOP,
        ST_FETCH,
        ST_EMIT
    } t_state;

    function automatic logic [ADDR_W-1:0] step_addr(input logic [STEP_W-1:0] step,
                                                    input logic [VOICE_W-1:0] voice);
        logic [ADDR_W-1:0] base;
        unique case (step)
            STEP_WAVE: base = REG_WAVE;
            STEP_F4:   base = REG_FREQ4;
            STEP_F3:   base = REG_FREQ3;
            STEP_F2:   base = REG_FREQ2;
            STEP_F1:   base = REG_FREQ1;
            STEP_F0:   base = REG_FREQ0;
            STEP_VOL:  base = REG_VOL;
            default:   base = REG_WAVE;
        endcase
        return ADDR_W'(base + ADDR_W'(voice) * VOICE_STRIDE);
    endfunction

endpackage

@@ design/three_voice_wave_sound_registers_top.sv @@
// Register front end of a three-voice wavetable sound chip.
// Requests: start with i_mode/i_offset/i_data, taken when start is high and
// busy is low. Register writes keep the low nibble in a 32-entry memory and
// flag a change if it differs; enable writes record data != 0; update ticks rebuild all
// voice commands when output is on, the chip is enabled and a change is
// pending. Commands leave on o_voice/o_command/o_rate/o_volume/o_wave/o_last,
// each valid for one cycle under o_strobe; the receiver cannot stall them.
// Config: i_cfg_valid/o_cfg_ready/i_cfg_data writes sound_output_on (idle only).
// Sequence, from the accepting edge:
//   register write: busy in ST_WRITE (read, then compare and write back).
//   enable write of zero: a stop for each voice in ST_STOP, one per
//   cycle, last one busy-free; nonzero or ignored items leave it idle.
//   update tick: per voice, ST_FETCH does the one-port memory fetch of the
//   seven nibbles and ST_EMIT forms the command, voice after voice; each
//   command shows in the cycle after it is formed.
// Reset: memory valid bits clear so every register reads zero, last waves
// read as none, chip disabled, sound output on. No clearing pass is needed.
module three_voice_wave_sound_registers_top #(
    parameter int VOICES = tvwsr_pkg::VOICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_mode,
    input  logic [tvwsr_pkg::ADDR_W-1:0]      i_offset,
    input  logic [tvwsr_pkg::DATA_W-1:0]      i_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    output logic                              o_strobe,
    output logic [tvwsr_pkg::VOICE_W-1:0]     o_voice,
    output logic [tvwsr_pkg::CMD_W-1:0]       o_command,
    output logic [tvwsr_pkg::RATE_W-1:0]      o_rate,
    output logic [tvwsr_pkg::VOL_W-1:0]       o_volume,
    output logic [tvwsr_pkg::WAVE_W-1:0]      o_wave,
    output logic                              o_last
);
    import tvwsr_pkg::*;

    t_state               r_state, n_state;
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    fetch_idx;
    logic [VOICE_W-1:0]   r_voice;
    logic                 last_voice;
    logic                 accept;
    logic                 upd_taken;

    logic [NIB_W-1:0]     r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [NIB_W-1:0]     r_rd_data;
    logic                 r_rd_ok;
    logic [NIB_W-1:0]     rd_nib;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;

    logic [ADDR_W-1:0]    r_addr;
    logic [NIB_W-1:0]     r_nib;

    logic                 r_enabled;
    logic                 r_changed;
    logic                 r_out_on;
    logic [LWAVE_W-1:0]   r_last_wave [VOICES];

    logic [WAVE_W-1:0]    r_wave;
    logic [FREQ_W-1:0]    r_freq;
    logic [NIB_W-1:0]     r_vol;
    logic [PROD_W-1:0]    prod;

    logic                 r_strobe;
    logic [VOICE_W-1:0]   r_out_voice;
    t_cmd                 r_out_cmd;
    logic [RATE_W-1:0]    r_out_rate;
    logic [VOL_W-1:0]     r_out_vol;
    logic [WAVE_W-1:0]    r_out_wave;
    logic                 r_out_last;

    assign last_voice = (r_voice == VOICE_W'(VOICES - 1));
    assign accept     = start && (r_state == ST_IDLE);
    assign upd_taken  = r_out_on && r_enabled && r_changed;
    assign rd_nib     = r_rd_ok ? r_rd_data : '0;
    assign fetch_idx  = r_step - STEP_W'(1);
    assign prod       = PROD_W'(r_freq) * PROD_W'(RATE_MUL);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (t_mode'(i_mode))
                        MODE_REG_WR: n_state = ST_WRITE;
                        MODE_ENABLE: n_state = (i_data == '0) ? ST_STOP : ST_IDLE;
                        MODE_UPDATE: n_state = upd_taken ? ST_FETCH : ST_IDLE;
                        MODE_NONE:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_STOP:  n_state = last_voice ? ST_IDLE : ST_STOP;
            ST_FETCH: n_state = (r_step == STEP_LAST) ? ST_EMIT : ST_FETCH;
            ST_EMIT:  n_state = last_voice ? ST_IDLE : ST_FETCH;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        busy    = (r_state != ST_IDLE);
        rd_addr = (r_state == ST_IDLE) ? i_offset : step_addr(r_step, r_voice);
        mem_we  = (r_state == ST_WRITE) && (rd_nib != r_nib);
    end

    assign o_cfg_ready = (r_state == ST_IDLE);

    // register file, one read port with registered data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= r_nib;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_voice   <= '0;
            r_valid   <= '0;
            r_enabled <= 1'b0;
            r_changed <= 1'b0;
            r_out_on  <= 1'b1;
            r_strobe  <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_last_wave[v] <= LAST_WAVE_NONE;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_STOP) || (r_state == ST_EMIT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_out_on <= i_cfg_data;
            end
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
                r_changed       <= 1'b1;
            end
            if (accept && (t_mode'(i_mode) == MODE_ENABLE)) begin
                r_enabled <= (i_data != '0);
            end
            if (accept && (t_mode'(i_mode) == MODE_UPDATE) && upd_taken) begin
                r_changed <= 1'b0;
            end
            // step wraps to zero on the way into ST_EMIT
            if (r_state == ST_FETCH) begin
                r_step <= r_step + STEP_W'(1);
            end else if (r_state == ST_IDLE) begin
                r_step <= '0;
            end
            if (r_state == ST_IDLE) begin
                r_voice <= '0;
            end else if ((r_state == ST_STOP) || (r_state == ST_EMIT)) begin
                r_voice <= r_voice + VOICE_W'(1);
            end
            if (r_state == ST_EMIT) begin
                r_last_wave[r_voice] <= LWAVE_W'(r_wave);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_offset;
            r_nib  <= i_data[NIB_W-1:0];
        end
        // data of step n-1 arrives while step n is issued
        if ((r_state == ST_FETCH) && (r_step != '0)) begin
            unique case (fetch_idx)
                STEP_WAVE: r_wave <= rd_nib[WAVE_W-1:0];
                STEP_F4, STEP_F3, STEP_F2, STEP_F1:
                    r_freq <= {r_freq[FREQ_W-NIB_W-1:0], rd_nib};
                STEP_F0:
                    r_freq <= {r_freq[FREQ_W-NIB_W-1:0],
                               (r_voice == '0) ? rd_nib : NIB_W'(0)};
                STEP_VOL:  r_vol <= rd_nib;
                default:   r_vol <= r_vol;
            endcase
        end
        if (r_state == ST_STOP) begin
            r_out_voice <= r_voice;
            r_out_cmd   <= CMD_STOP;
            r_out_rate  <= '0;
            r_out_vol   <= '0;
            r_out_wave  <= '0;
            r_out_last  <= last_voice;
        end else if (r_state == ST_EMIT) begin
            r_out_voice <= r_voice;
            r_out_cmd   <= (LWAVE_W'(r_wave) != r_last_wave[r_voice]) ? CMD_PLAY : CMD_ADJUST;
            r_out_rate  <= prod[RATE_SHIFT +: RATE_W];
            r_out_vol   <= {r_vol, r_vol};
            r_out_wave  <= r_wave;
            r_out_last  <= last_voice;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_voice   = r_out_voice;
    assign o_command = r_out_cmd;
    assign o_rate    = r_out_rate;
    assign o_volume  = r_out_vol;
    assign o_wave    = r_out_wave;
    assign o_last    = r_out_last;

endmodule

@@ design/tvwsr_checker.sv @@
`include "three_voice_wave_sound_registers_top_assert.svh"

module tvwsr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [1:0]                        i_mode,
    input logic                              o_strobe,
    input logic [tvwsr_pkg::VOICE_W-1:0]     o_voice,
    input logic [tvwsr_pkg::CMD_W-1:0]       o_command,
    input logic [tvwsr_pkg::RATE_W-1:0]      o_rate,
    input logic [tvwsr_pkg::VOL_W-1:0]       o_volume,
    input logic [tvwsr_pkg::WAVE_W-1:0]      o_wave,
    input logic                              o_last
);
    import tvwsr_pkg::*;

    // stop commands carry no rate, volume or wave
    `TVWSR_ASSERT_NOW(a_stop_payload, o_strobe && (o_command == CMD_STOP),
        (o_rate == '0) && (o_volume == '0) && (o_wave == '0), "stop with payload")

    `TVWSR_ASSERT_NOW(a_vol_dup, o_strobe,
        o_volume[7:4] == o_volume[3:0], "volume halves differ")

    // a register write request produces no command
    `TVWSR_ASSERT_NEXT(a_wr_silent, start && !busy && (i_mode == MODE_REG_WR),
        !o_strobe, "command after register write")

    // stops run back to back over the voices
    `TVWSR_ASSERT_NEXT(a_stop_seq, o_strobe && (o_command == CMD_STOP) && !o_last,
        o_strobe && (o_command == CMD_STOP) &&
        (o_voice == VOICE_W'($past(o_voice) + VOICE_W'(1))), "stop sequence broken")

endmodule

bind three_voice_wave_sound_registers_top tvwsr_checker u_tvwsr_checker (.*);
